>>> rtl/lhot_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the luma histogram Otsu threshold core.
package lhot_pkg;

    localparam int unsigned MAX_PIXELS = 1048576;
    localparam int unsigned CNT_W      = 21;
    localparam int unsigned LUMA_W     = 8;
    localparam int unsigned BINS       = 256;
    localparam int unsigned SUM_W      = 28;
    localparam int unsigned D_W        = 48;
    localparam int unsigned DD_W       = 96;
    localparam int unsigned P_W        = 144;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_W     = 2;
    localparam int unsigned LACC_W     = 23;

    localparam logic [13:0] K_RED   = 14'd4899;
    localparam logic [13:0] K_GREEN = 14'd9617;
    localparam logic [13:0] K_BLUE  = 14'd1868;
    localparam logic [13:0] K_ROUND = 14'd8192;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic              cnt_en;
        logic              last;
    } t_pix;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_RUN,
        B_DRAIN,
        B_RD,
        B_ACC,
        B_PA,
        B_PC,
        B_DQ,
        B_SQ,
        B_LHS,
        B_RHS,
        B_CMP,
        B_NEXT,
        B_OUT
    } t_bstate;

    function automatic logic [LUMA_W-1:0] luma_of(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        logic [LACC_W-1:0] acc;
        acc = LACC_W'(r * K_RED) + LACC_W'(g * K_GREEN) + LACC_W'(b * K_BLUE)
            + LACC_W'(K_ROUND);
        return acc[LACC_W-2:14];
    endfunction

endpackage

>>> rtl/lhot_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixel words, converts to luma and marks counted pixels.
module lhot_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic                i_frame_end,
    input  logic                i_q_full,
    input  logic                i_clearing,
    output logic                o_push,
    output lhot_pkg::t_pix      o_pix
);
    logic [lhot_pkg::CNT_W-1:0] r_seen;
    logic [lhot_pkg::CNT_W-1:0] n_seen;
    logic                       cnt_en;

    assign o_stall = i_q_full || i_clearing;
    assign o_push  = i_valid && !o_stall;
    assign cnt_en  = r_seen < lhot_pkg::CNT_W'(lhot_pkg::MAX_PIXELS);

    assign o_pix.luma   = lhot_pkg::luma_of(i_red, i_green, i_blue);
    assign o_pix.cnt_en = cnt_en;
    assign o_pix.last   = i_frame_end;

    always_comb begin
        n_seen = r_seen;
        if (o_push) begin
            if (i_frame_end) begin
                n_seen = '0;
            end else if (cnt_en) begin
                n_seen = r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end
endmodule

>>> rtl/lhot_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified pixels between front and back.
module lhot_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lhot_pkg::t_pix i_pix,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lhot_pkg::t_pix o_head
);
    lhot_pkg::t_pix                r_ent [0:lhot_pkg::QDEPTH-1];
    logic [lhot_pkg::QPTR_W-1:0]   r_wp;
    logic [lhot_pkg::QPTR_W-1:0]   r_rp;
    logic [lhot_pkg::QPTR_W:0]     r_cnt;

    assign o_full  = r_cnt == (lhot_pkg::QPTR_W+1)'(lhot_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> rtl/lhot_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle, stops when bits run out.
module lhot_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lhot_pkg::DD_W-1:0] i_a,
    input  logic [lhot_pkg::D_W-1:0]  i_b,
    output logic                      o_done,
    output logic [lhot_pkg::P_W-1:0]  o_prod
);
    logic                      r_busy;
    logic [lhot_pkg::P_W-1:0]  r_acc;
    logic [lhot_pkg::P_W-1:0]  r_mc;
    logic [lhot_pkg::D_W-1:0]  r_mp;

    assign o_done = r_busy && (r_mp == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= lhot_pkg::P_W'(i_a);
            r_mp  <= i_b;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

>>> rtl/lhot_back.sv
`timescale 1ns / 1ps
// Back end: histogram update, clearing sweep, Otsu scan and result register.
module lhot_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  lhot_pkg::t_pix                     i_head,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_threshold,
    output logic                               o_no_split,
    output logic [lhot_pkg::CNT_W-1:0]         o_pixel_total
);
    localparam int unsigned CW = lhot_pkg::CNT_W;
    localparam int unsigned LW = lhot_pkg::LUMA_W;

    lhot_pkg::t_bstate r_state;
    lhot_pkg::t_bstate n_state;

    logic [CW-1:0] r_mem [0:lhot_pkg::BINS-1];
    logic [CW-1:0] r_rdata;
    logic          mem_we;
    logic [LW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [LW-1:0] mem_raddr;

    logic           r_a_vld;
    lhot_pkg::t_pix r_a;
    logic           r_b_vld;
    lhot_pkg::t_pix r_b;
    logic           r_w_vld;
    logic [LW-1:0]  r_w_addr;
    logic [CW-1:0]  r_w_val;
    logic [CW-1:0]  cur_cnt;
    logic           cnt_we;

    logic [LW-1:0]                   r_idx;
    logic [CW-1:0]                   r_total;
    logic [lhot_pkg::SUM_W-1:0]      r_sum;
    logic [CW-1:0]                   r_w0;
    logic [lhot_pkg::SUM_W-1:0]      r_s0;
    logic [lhot_pkg::D_W-1:0]        r_pa;
    logic [lhot_pkg::D_W-1:0]        r_pc;
    logic [lhot_pkg::D_W-1:0]        r_d;
    logic [lhot_pkg::D_W-1:0]        r_q;
    logic [lhot_pkg::DD_W-1:0]       r_dd;
    logic [lhot_pkg::DD_W-1:0]       r_best_dd;
    logic [lhot_pkg::D_W-1:0]        r_best_q;
    logic [lhot_pkg::P_W-1:0]        r_lhs;
    logic [LW-1:0]                   r_thr;
    logic                            r_found;
    logic                            r_issued;

    logic                            mul_start;
    logic [lhot_pkg::DD_W-1:0]       mul_a;
    logic [lhot_pkg::D_W-1:0]        mul_b;
    logic                            mul_done;
    logic [lhot_pkg::P_W-1:0]        mul_prod;
    logic                            mul_wait;

    lhot_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Forward the previous write: its edge coincides with this item's read.
    assign cur_cnt = (r_w_vld && r_w_addr == r_b.luma) ? r_w_val : r_rdata;
    assign cnt_we  = r_b_vld && r_b.cnt_en;

    assign mul_wait   = (r_state == lhot_pkg::B_SQ) || (r_state == lhot_pkg::B_LHS)
                     || (r_state == lhot_pkg::B_RHS);
    assign mul_start  = mul_wait && !r_issued;
    assign o_clearing = r_state == lhot_pkg::B_CLEAR;
    assign o_valid    = r_state == lhot_pkg::B_OUT;
    assign o_threshold   = r_thr;
    assign o_no_split    = !r_found;
    assign o_pixel_total = r_total;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        mem_raddr = r_a.luma;
        mem_we    = cnt_we;
        mem_waddr = r_b.luma;
        mem_wdata = cur_cnt + 1'b1;
        mul_a     = lhot_pkg::DD_W'(r_d);
        mul_b     = r_d;
        case (r_state)
            lhot_pkg::B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = '0;
                if (r_idx == LW'(lhot_pkg::BINS - 1)) begin
                    n_state = lhot_pkg::B_RUN;
                end
            end
            lhot_pkg::B_RUN: begin
                o_pop = !i_q_empty;
                if (!i_q_empty && i_head.last) begin
                    n_state = lhot_pkg::B_DRAIN;
                end
            end
            lhot_pkg::B_DRAIN: begin
                if (r_b_vld && r_b.last) begin
                    n_state = lhot_pkg::B_RD;
                end
            end
            lhot_pkg::B_RD: begin
                // read the bin and zero it for the next frame
                mem_raddr = r_idx;
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = '0;
                n_state   = lhot_pkg::B_ACC;
            end
            lhot_pkg::B_ACC: n_state = lhot_pkg::B_PA;
            lhot_pkg::B_PA: begin
                if (r_w0 == '0 || r_w0 == r_total) begin
                    n_state = lhot_pkg::B_NEXT;
                end else begin
                    n_state = lhot_pkg::B_PC;
                end
            end
            lhot_pkg::B_PC: n_state = lhot_pkg::B_DQ;
            lhot_pkg::B_DQ: n_state = lhot_pkg::B_SQ;
            lhot_pkg::B_SQ: begin
                if (mul_done && r_issued) begin
                    n_state = r_found ? lhot_pkg::B_LHS : lhot_pkg::B_NEXT;
                end
            end
            lhot_pkg::B_LHS: begin
                mul_a = r_dd;
                mul_b = r_best_q;
                if (mul_done && r_issued) begin
                    n_state = lhot_pkg::B_RHS;
                end
            end
            lhot_pkg::B_RHS: begin
                mul_a = r_best_dd;
                mul_b = r_q;
                if (mul_done && r_issued) begin
                    n_state = lhot_pkg::B_CMP;
                end
            end
            lhot_pkg::B_CMP: n_state = lhot_pkg::B_NEXT;
            lhot_pkg::B_NEXT: begin
                if (r_idx == LW'(lhot_pkg::BINS - 1)) begin
                    n_state = lhot_pkg::B_OUT;
                end else begin
                    n_state = lhot_pkg::B_RD;
                end
            end
            lhot_pkg::B_OUT: begin
                if (!i_stall) begin
                    n_state = lhot_pkg::B_RUN;
                end
            end
            default: n_state = lhot_pkg::B_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhot_pkg::B_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_a      <= i_head;
        r_b      <= r_a;
        r_w_addr <= r_b.luma;
        r_w_val  <= cur_cnt + 1'b1;
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_w_vld <= 1'b0;
        end else begin
            r_a_vld <= o_pop;
            r_b_vld <= r_a_vld;
            r_w_vld <= cnt_we;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lhot_pkg::B_DRAIN: begin
                r_w0  <= '0;
                r_s0  <= '0;
                r_thr <= '0;
            end
            lhot_pkg::B_ACC: begin
                r_w0 <= r_w0 + r_rdata;
                r_s0 <= r_s0 + lhot_pkg::SUM_W'(r_idx * r_rdata);
            end
            lhot_pkg::B_PA: r_pa <= lhot_pkg::D_W'(r_s0 * r_total);
            lhot_pkg::B_PC: r_pc <= lhot_pkg::D_W'(r_sum * r_w0);
            lhot_pkg::B_DQ: begin
                r_d <= (r_pa > r_pc) ? (r_pa - r_pc) : (r_pc - r_pa);
                r_q <= lhot_pkg::D_W'(r_w0 * (r_total - r_w0));
            end
            lhot_pkg::B_SQ: begin
                if (mul_done && r_issued) begin
                    r_dd <= mul_prod[lhot_pkg::DD_W-1:0];
                    if (!r_found) begin
                        r_best_dd <= mul_prod[lhot_pkg::DD_W-1:0];
                        r_best_q  <= r_q;
                        r_thr     <= r_idx;
                    end
                end
            end
            lhot_pkg::B_LHS: begin
                if (mul_done && r_issued) begin
                    r_lhs <= mul_prod;
                end
            end
            lhot_pkg::B_CMP: begin
                // strictly greater replaces, so ties keep the lower bin
                if (r_lhs > mul_prod) begin
                    r_best_dd <= r_dd;
                    r_best_q  <= r_q;
                    r_thr     <= r_idx;
                end
            end
            default: begin
                r_pa <= r_pa;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_total  <= '0;
            r_sum    <= '0;
            r_found  <= 1'b0;
            r_issued <= 1'b0;
        end else begin
            if (mul_start) begin
                r_issued <= 1'b1;
            end else if (mul_done) begin
                r_issued <= 1'b0;
            end
            case (r_state)
                lhot_pkg::B_CLEAR: r_idx <= r_idx + 1'b1;
                lhot_pkg::B_RUN: begin
                    if (o_pop && i_head.cnt_en) begin
                        r_total <= r_total + 1'b1;
                        r_sum   <= r_sum + lhot_pkg::SUM_W'(i_head.luma);
                    end
                end
                lhot_pkg::B_DRAIN: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                lhot_pkg::B_SQ: begin
                    if (mul_done && r_issued) begin
                        r_found <= 1'b1;
                    end
                end
                lhot_pkg::B_NEXT: begin
                    if (r_idx != LW'(lhot_pkg::BINS - 1)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                lhot_pkg::B_OUT: begin
                    if (!i_stall) begin
                        r_total <= '0;
                        r_sum   <= '0;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end
endmodule

>>> rtl/luma_histogram_otsu_threshold_core.sv
`timescale 1ns / 1ps
// Top level of the luma histogram Otsu threshold core.
//
// Input channel: one RGB pixel word per accepted transfer (i_valid high,
// o_stall low); i_frame_end marks the last pixel of a frame. Pixels are
// converted to luma and queued (four words deep) toward the histogram, which
// takes one pixel per cycle while counting, so pixels stream in at one per
// clock. After the frame_end pixel leaves the queue and the two-stage bin
// update drains, the back end scans the 256 bins once. A bin where one class
// is empty is read, accumulated and skipped; a bin that splits the frame also
// forms the cross terms, their difference and the class product, then uses
// the shared shift-add multiplier for the square and, once a best bin exists,
// for the two cross products. Pixels of the next frame fill the queue
// meanwhile and then o_stall rises until the result word is taken.
// Output channel: one result word per frame (threshold, no_split,
// pixel_total), held in place while i_stall is high; the back end resumes
// counting once the word is taken.
// Reset: synchronous, active low. A sweep then zeroes all 256 histogram
// bins with o_stall high; pixels beyond 1048576 in a frame are dropped.
module luma_histogram_otsu_threshold_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_red,
    input  logic [7:0]                  i_green,
    input  logic [7:0]                  i_blue,
    input  logic                        i_frame_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_threshold,
    output logic                        o_no_split,
    output logic [lhot_pkg::CNT_W-1:0]  o_pixel_total
);
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    logic           clearing;
    lhot_pkg::t_pix pix;
    lhot_pkg::t_pix head;

    lhot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_frame_end (i_frame_end),
        .i_q_full    (q_full),
        .i_clearing  (clearing),
        .o_push      (push),
        .o_pix       (pix)
    );

    lhot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (pix),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    lhot_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_threshold   (o_threshold),
        .o_no_split    (o_no_split),
        .o_pixel_total (o_pixel_total)
    );
endmodule

>>> rtl/lhot_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the luma histogram Otsu threshold core, with bind.
module lhot_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [7:0]                  o_threshold,
    input logic                        o_no_split,
    input logic [lhot_pkg::CNT_W-1:0]  o_pixel_total
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_threshold)
            && $stable(o_no_split) && $stable(o_pixel_total))
        else $error("result word changed while stalled");

    a_no_split_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_split |-> o_threshold == 8'd0)
        else $error("no split result with nonzero threshold");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_total != '0)
        else $error("result word with empty frame");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("result or acceptance right after reset");
endmodule

bind luma_histogram_otsu_threshold_core lhot_checker u_lhot_checker (.*);
